>>> rtl/core/powc_pkg.sv
// Package: payload types, widths, register indexes and the saturation helper of the obstacle and wall collision block.
package powc_pkg;

   localparam int FX_W       = 20;
   localparam int D_W        = 21;
   localparam int SQ_W       = 41;
   localparam int R2_W       = 38;
   localparam int ROOT_IN_W  = 58;
   localparam int ROOT_STEPS = 29;
   localparam int REM_W      = 47;
   localparam int Q_W        = 18;
   localparam int N_W        = 19;
   localparam int PROD_W     = 39;
   localparam int DOT_W      = 41;
   localparam int DN_W       = 60;
   localparam int CSR_W      = 60;
   localparam int WIDE_W     = 30;
   localparam int FX_ONE     = 65536;

   typedef logic signed [FX_W-1:0] fx_type;
   typedef logic signed [D_W-1:0]  d_type;

   typedef enum logic [2:0] {
      CSR_CENTER      = 3'd0,
      CSR_OBST_VEL    = 3'd1,
      CSR_CONTACT     = 3'd2,
      CSR_WALL_LOW    = 3'd3,
      CSR_WALL_HIGH_X = 3'd4,
      CSR_WALL_HIGH_Y = 3'd5,
      CSR_WALL_HIGH_Z = 3'd6
   } csr_index_type;

   typedef struct packed {
      fx_type pos_x;
      fx_type pos_y;
      fx_type pos_z;
      fx_type vel_x;
      fx_type vel_y;
      fx_type vel_z;
   } req_type;

   typedef struct packed {
      fx_type new_pos_x;
      fx_type new_pos_y;
      fx_type new_pos_z;
      fx_type new_vel_x;
      fx_type new_vel_y;
      fx_type new_vel_z;
   } rsp_type;

   // Per-item values that ride along the pipeline.
   typedef struct packed {
      logic            contact;
      logic            zero;
      fx_type [2:0]    p;
      fx_type [2:0]    v;
      d_type  [2:0]    d;
   } carry_type;

   function automatic fx_type sat_fx(input logic signed [WIDE_W-1:0] x);
      fx_type res;
      if (x > WIDE_W'(signed'(524287))) begin
         res = 20'sd524287;
      end else if (x < -WIDE_W'(signed'(524288))) begin
         res = -20'sd524288;
      end else begin
         res = x[FX_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> rtl/core/particle_obstacle_wall_collision.sv
// Top level: pipelined sphere obstacle response followed by box wall clamps.
//
// Usage:
//  - Input channel: an item (req_data) transfers at a rising edge with start high
//    and busy low. busy is always low: the pipeline takes one item every cycle.
//  - Result channel: rsp_strobe is high for exactly one cycle with rsp_data; the
//    receiver cannot stall, so no back-pressure exists anywhere.
//  - Config: csr_we/csr_index/csr_wdata write one register per edge; indexes
//    beyond the list are dropped. Write only while no item is in flight.
//  - Pipeline: 57 register stages, from the capture register to the output
//    register, with no stall anywhere.
//    Throughput: one item per cycle.
//  - Most stages belong to the 29-step square root (one result bit per stage) and
//    the 18-step restoring dividers (one quotient bit per stage, one per axis).
//  - Reset (synchronous, active high) clears all valid bits and all config
//    registers to zero; items in flight are dropped.
//  - Flow: distance and squares, contact test, sqrt of D2, normal by division,
//    dot product and projections, saturation, then per-axis wall clamps.
module particle_obstacle_wall_collision
   import powc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [CSR_W-1:0] center_ff, ovel_ff;
   logic [18:0]      contact_ff;
   fx_type           wall_low_ff;
   fx_type [2:0]     wall_high_ff;
   logic [R2_W-1:0]  r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff    <= '0;
         ovel_ff      <= '0;
         contact_ff   <= '0;
         wall_low_ff  <= '0;
         wall_high_ff <= '0;
         r2_ff        <= '0;
      end else begin
         r2_ff <= R2_W'(contact_ff) * R2_W'(contact_ff);
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_CENTER:      center_ff       <= csr_wdata;
               CSR_OBST_VEL:    ovel_ff         <= csr_wdata;
               CSR_CONTACT:     contact_ff      <= csr_wdata[18:0];
               CSR_WALL_LOW:    wall_low_ff     <= csr_wdata[FX_W-1:0];
               CSR_WALL_HIGH_X: wall_high_ff[0] <= csr_wdata[FX_W-1:0];
               CSR_WALL_HIGH_Y: wall_high_ff[1] <= csr_wdata[FX_W-1:0];
               CSR_WALL_HIGH_Z: wall_high_ff[2] <= csr_wdata[FX_W-1:0];
               default: ;
            endcase
         end
      end
   end

   fx_type [2:0] ctr, ov;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ctr[i] = center_ff[FX_W*i +: FX_W];
         ov[i]  = ovel_ff[FX_W*i +: FX_W];
      end
   end

   assign busy = 1'b0;

   // ---------------- stage 0: capture, offsets ----------------
   logic      s0_v_ff;
   carry_type s0_ff;
   carry_type s0_in;

   always_comb begin
      s0_in         = '0;
      s0_in.p[0]    = req_data.pos_x;
      s0_in.p[1]    = req_data.pos_y;
      s0_in.p[2]    = req_data.pos_z;
      s0_in.v[0]    = req_data.vel_x;
      s0_in.v[1]    = req_data.vel_y;
      s0_in.v[2]    = req_data.vel_z;
      for (int i = 0; i < 3; i++) begin
         s0_in.d[i] = D_W'($signed(s0_in.p[i])) - D_W'($signed(ctr[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s0_v_ff <= 1'b0;
      else       s0_v_ff <= start;
      s0_ff <= s0_in;
   end

   // ---------------- stage 1: squares ----------------
   logic            s1_v_ff;
   carry_type       s1_ff;
   logic [SQ_W-1:0] s1_sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else       s1_v_ff <= s0_v_ff;
      s1_ff <= s0_ff;
      for (int i = 0; i < 3; i++) begin
         s1_sq_ff[i] <= SQ_W'($signed(s0_ff.d[i]) * $signed(s0_ff.d[i]));
      end
   end

   // ---------------- stage 2: D2, contact test ----------------
   logic [SQ_W+1:0] d2;
   carry_type       s2_in;
   assign d2 = (SQ_W+2)'(s1_sq_ff[0]) + (SQ_W+2)'(s1_sq_ff[1]) + (SQ_W+2)'(s1_sq_ff[2]);

   always_comb begin
      s2_in         = s1_ff;
      s2_in.contact = d2 < (SQ_W+2)'(r2_ff);
      s2_in.zero    = d2 == '0;
   end

   // sqrt pipeline: index 0 is the stage-2 register
   logic                 sq_v_ff [0:ROOT_STEPS];
   carry_type            sq_c_ff [0:ROOT_STEPS];
   logic [ROOT_IN_W-1:0] sq_x_ff [0:ROOT_STEPS];
   logic [ROOT_IN_W-1:0] sq_r_ff [0:ROOT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) sq_v_ff[0] <= 1'b0;
      else       sq_v_ff[0] <= s1_v_ff;
      sq_c_ff[0] <= s2_in;
      // only the contact case uses the root, where D2 < 2^38
      sq_x_ff[0] <= {d2[R2_W-1:0], 20'b0};
      sq_r_ff[0] <= '0;
   end

   for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
      localparam int K = ROOT_STEPS - 1 - g;
      localparam logic [ROOT_IN_W-1:0] BIT = ROOT_IN_W'(1) << (2 * K);
      logic [ROOT_IN_W-1:0] trial;
      assign trial = sq_r_ff[g] + BIT;
      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[g+1] <= 1'b0;
         else       sq_v_ff[g+1] <= sq_v_ff[g];
         sq_c_ff[g+1] <= sq_c_ff[g];
         if (sq_x_ff[g] >= trial) begin
            sq_x_ff[g+1] <= sq_x_ff[g] - trial;
            sq_r_ff[g+1] <= (sq_r_ff[g] >> 1) + BIT;
         end else begin
            sq_x_ff[g+1] <= sq_x_ff[g];
            sq_r_ff[g+1] <= sq_r_ff[g] >> 1;
         end
      end
   end

   // ---------------- divider: n = round(|d| * 2^26 / L) ----------------
   logic             dv_v_ff   [0:Q_W];
   carry_type        dv_c_ff   [0:Q_W];
   logic [28:0]      dv_l_ff   [0:Q_W];
   logic [REM_W-1:0] dv_rem_ff [0:Q_W][3];
   logic [Q_W-1:0]   dv_q_ff   [0:Q_W][3];

   logic [28:0] root_len;
   assign root_len = sq_r_ff[ROOT_STEPS][28:0];

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else       dv_v_ff[0] <= sq_v_ff[ROOT_STEPS];
      dv_c_ff[0] <= sq_c_ff[ROOT_STEPS];
      dv_l_ff[0] <= root_len;
      for (int i = 0; i < 3; i++) begin
         dv_rem_ff[0][i] <= REM_W'({(sq_c_ff[ROOT_STEPS].d[i][D_W-1]
                                     ? -sq_c_ff[ROOT_STEPS].d[i]
                                     : sq_c_ff[ROOT_STEPS].d[i]), 26'b0})
                            + REM_W'(root_len >> 1);
         dv_q_ff[0][i]   <= '0;
      end
   end

   for (genvar g = 0; g < Q_W; g++) begin : g_div
      localparam int K = Q_W - 1 - g;
      logic [REM_W-1:0] dsub;
      assign dsub = REM_W'(dv_l_ff[g]) << K;
      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[g+1] <= 1'b0;
         else       dv_v_ff[g+1] <= dv_v_ff[g];
         dv_c_ff[g+1] <= dv_c_ff[g];
         dv_l_ff[g+1] <= dv_l_ff[g];
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_ff[g][i] >= dsub) begin
               dv_rem_ff[g+1][i] <= dv_rem_ff[g][i] - dsub;
               dv_q_ff[g+1][i]   <= dv_q_ff[g][i] | (Q_W'(1) << K);
            end else begin
               dv_rem_ff[g+1][i] <= dv_rem_ff[g][i];
               dv_q_ff[g+1][i]   <= dv_q_ff[g][i];
            end
         end
      end
   end

   // ---------------- normal, sign and zero-distance override ----------------
   logic                  nm_v_ff;
   carry_type             nm_c_ff;
   logic signed [N_W-1:0] nm_n_ff [3];

   always_ff @(posedge clock) begin
      if (reset) nm_v_ff <= 1'b0;
      else       nm_v_ff <= dv_v_ff[Q_W];
      nm_c_ff <= dv_c_ff[Q_W];
      for (int i = 0; i < 3; i++) begin
         if (dv_c_ff[Q_W].zero) begin
            nm_n_ff[i] <= (i == 0) ? N_W'(FX_ONE) : '0;
         end else if (dv_c_ff[Q_W].d[i][D_W-1]) begin
            nm_n_ff[i] <= -$signed(N_W'(dv_q_ff[Q_W][i]));
         end else begin
            nm_n_ff[i] <= N_W'(dv_q_ff[Q_W][i]);
         end
      end
   end

   // ---------------- M1: v*n and n*R ----------------
   logic                     m1_v_ff;
   carry_type                m1_c_ff;
   logic signed [N_W-1:0]    m1_n_ff  [3];
   logic signed [PROD_W-1:0] m1_vn_ff [3];
   logic signed [PROD_W-1:0] m1_pn_ff [3];

   always_ff @(posedge clock) begin
      if (reset) m1_v_ff <= 1'b0;
      else       m1_v_ff <= nm_v_ff;
      m1_c_ff <= nm_c_ff;
      for (int i = 0; i < 3; i++) begin
         m1_n_ff[i]  <= nm_n_ff[i];
         m1_vn_ff[i] <= PROD_W'($signed(nm_c_ff.v[i]) * nm_n_ff[i]);
         m1_pn_ff[i] <= PROD_W'(nm_n_ff[i] * $signed({1'b0, contact_ff}));
      end
   end

   // ---------------- M2: dot product, contact point ----------------
   logic                    m2_v_ff;
   carry_type               m2_c_ff;
   logic signed [N_W-1:0]   m2_n_ff  [3];
   logic signed [DOT_W-1:0] m2_dot_ff;
   logic signed [23:0]      m2_pc_ff [3];

   always_ff @(posedge clock) begin
      if (reset) m2_v_ff <= 1'b0;
      else       m2_v_ff <= m1_v_ff;
      m2_c_ff   <= m1_c_ff;
      m2_dot_ff <= DOT_W'(m1_vn_ff[0]) + DOT_W'(m1_vn_ff[1]) + DOT_W'(m1_vn_ff[2]);
      for (int i = 0; i < 3; i++) begin
         m2_n_ff[i]  <= m1_n_ff[i];
         m2_pc_ff[i] <= 24'($signed(ctr[i]))
                        + 24'((m1_pn_ff[i] + PROD_W'(32768)) >>> 16);
      end
   end

   // ---------------- M3: dot*n ----------------
   logic                   m3_v_ff;
   carry_type              m3_c_ff;
   logic signed [23:0]     m3_pc_ff [3];
   logic signed [DN_W-1:0] m3_dn_ff [3];

   always_ff @(posedge clock) begin
      if (reset) m3_v_ff <= 1'b0;
      else       m3_v_ff <= m2_v_ff;
      m3_c_ff <= m2_c_ff;
      for (int i = 0; i < 3; i++) begin
         m3_pc_ff[i] <= m2_pc_ff[i];
         m3_dn_ff[i] <= DN_W'(m2_dot_ff * m2_n_ff[i]);
      end
   end

   // ---------------- M4: tangential velocity, saturation, select ----------------
   logic         m4_v_ff;
   fx_type [2:0] m4_p_ff, m4_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) m4_v_ff <= 1'b0;
      else       m4_v_ff <= m3_v_ff;
      for (int i = 0; i < 3; i++) begin
         if (m3_c_ff.contact) begin
            m4_p_ff[i]   <= sat_fx(WIDE_W'(m3_pc_ff[i]));
            m4_vel_ff[i] <= sat_fx(WIDE_W'($signed(m3_c_ff.v[i]))
                                   - WIDE_W'((m3_dn_ff[i] + DN_W'(64'sd2147483648)) >>> 32)
                                   + WIDE_W'($signed(ov[i])));
         end else begin
            m4_p_ff[i]   <= m3_c_ff.p[i];
            m4_vel_ff[i] <= m3_c_ff.v[i];
         end
      end
   end

   // ---------------- wall clamps and output register ----------------
   logic         out_v_ff;
   fx_type [2:0] out_p_ff, out_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else       out_v_ff <= m4_v_ff;
      for (int i = 0; i < 3; i++) begin
         // upper wall wins when walls cross
         priority if ($signed(m4_p_ff[i]) > $signed(wall_high_ff[i])
                      || ($signed(m4_p_ff[i]) < $signed(wall_low_ff)
                          && $signed(wall_low_ff) > $signed(wall_high_ff[i]))) begin
            out_p_ff[i]   <= wall_high_ff[i];
            out_vel_ff[i] <= '0;
         end else if ($signed(m4_p_ff[i]) < $signed(wall_low_ff)) begin
            out_p_ff[i]   <= wall_low_ff;
            out_vel_ff[i] <= '0;
         end else begin
            out_p_ff[i]   <= m4_p_ff[i];
            out_vel_ff[i] <= m4_vel_ff[i];
         end
      end
   end

   assign rsp_strobe         = out_v_ff;
   assign rsp_data.new_pos_x = out_p_ff[0];
   assign rsp_data.new_pos_y = out_p_ff[1];
   assign rsp_data.new_pos_z = out_p_ff[2];
   assign rsp_data.new_vel_x = out_vel_ff[0];
   assign rsp_data.new_vel_y = out_vel_ff[1];
   assign rsp_data.new_vel_z = out_vel_ff[2];

endmodule
